/* design/isp_flash_programmer_sequencer_unit_macros.svh */
// assertion macros for the serial programmer checker
`ifndef ISP_FLASH_PROGRAMMER_SEQUENCER_UNIT_MACROS_SVH
`define ISP_FLASH_PROGRAMMER_SEQUENCER_UNIT_MACROS_SVH

// implication checked on every edge outside reset
`define ISPFP_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// a word held back by stall stays put on the next edge
`define ISPFP_HOLD(lbl, vld, stl, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (vld && stl) |=> (vld && $stable(sig))) else $error(msg);

`endif

/* design/ispfp_pkg.sv */
// types, codes and frame builder for the serial programmer
package ispfp_pkg;

    localparam int unsigned ADDR_BITS_DEF = 16;
    localparam int unsigned FRAME_BITS    = 32;

    localparam logic [7:0] ENABLE_ECHO  = 8'h69;
    localparam logic [7:0] PROG_ENABLE  = 8'hac;
    localparam logic [7:0] ENABLE_B1    = 8'h53;
    localparam logic [7:0] ENABLE_B3    = 8'h11;
    localparam logic [7:0] ERASE_B1     = 8'h80;
    localparam logic [7:0] ERASE_B2     = 8'h12;
    localparam logic [7:0] ERASE_B3     = 8'h13;
    localparam logic [7:0] READ_INSTR   = 8'h20;
    localparam logic [7:0] WRITE_INSTR  = 8'h40;

    typedef enum logic [2:0] {
        OP_BEGIN = 3'd0,
        OP_ERASE = 3'd1,
        OP_WRITE = 3'd2,
        OP_READ  = 3'd3,
        OP_END   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_ENABLE_FAIL = 2'd1,
        ST_VERIFY_FAIL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LOW  = 2'd1,
        PH_HIGH = 2'd2
    } phase_t;

    typedef struct packed {
        logic        cmd_valid;
        logic [2:0]  opcode;
        logic [15:0] address;
        logic [7:0]  wr_data;
        logic        miso;
    } item_t;

    typedef struct packed {
        logic        sck;
        logic        mosi;
        logic        target_reset;
        logic        busy;
        logic        done;
        status_t     status;
        logic [7:0]  read_byte;
    } result_t;

    // four instruction bytes, first byte in the top bits
    function automatic logic [31:0] build_frame(op_t op, logic [15:0] addr,
                                                logic [7:0] data);
        logic [31:0] frame;
        begin
            unique case (op)
                OP_BEGIN: frame = {PROG_ENABLE, ENABLE_B1, 8'h00, ENABLE_B3};
                OP_ERASE: frame = {PROG_ENABLE, ERASE_B1, ERASE_B2, ERASE_B3};
                OP_WRITE: frame = {WRITE_INSTR, addr, data};
                default:  frame = {READ_INSTR, addr, 8'h00};
            endcase
            return frame;
        end
    endfunction

endpackage

/* design/ispfp_seq_core.sv */
// frame sequencer state and the per-tick pin logic
module ispfp_seq_core #(
    parameter int unsigned ADDR_BITS = ispfp_pkg::ADDR_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  ispfp_pkg::item_t  item,
    input  logic [7:0]        half_period,
    output ispfp_pkg::result_t result
);
    import ispfp_pkg::*;

    localparam logic [15:0] ADDR_MASK = 16'((32'd1 << ADDR_BITS) - 32'd1);
    localparam logic [4:0]  BIT_LAST  = 5'(FRAME_BITS - 1);

    phase_t      phase_reg, phase_next;
    logic [4:0]  bit_reg, bit_next;
    logic [31:0] tx_reg, tx_next;
    logic [7:0]  rx_reg, rx_next;
    logic [7:0]  div_reg, div_next;
    op_t         held_reg, held_next;
    logic [7:0]  exp_reg, exp_next;
    logic        rl_reg, rl_next;

    logic        is_idle, start, stop_cmd, half_end, last_bit, sample;
    phase_t      ph_e;
    logic [7:0]  div_e, hp;
    logic [8:0]  div_inc;
    logic [4:0]  bit_e;

    assign is_idle  = (phase_reg == PH_IDLE);
    assign start    = is_idle && item.cmd_valid && (item.opcode <= 3'(OP_READ));
    assign stop_cmd = is_idle && item.cmd_valid && (item.opcode == 3'(OP_END));
    assign ph_e     = start ? PH_LOW : phase_reg;
    assign div_e    = start ? 8'd0 : div_reg;
    assign bit_e    = start ? 5'd0 : bit_reg;
    assign hp       = (half_period == 8'd0) ? 8'd1 : half_period;
    assign div_inc  = {1'b0, div_e} + 9'd1;
    assign half_end = (div_inc >= {1'b0, hp});
    assign last_bit = (bit_e == BIT_LAST);
    assign sample   = (ph_e == PH_HIGH) && half_end;

    // phase sequencing
    always_comb
    begin
        unique case (ph_e)
            PH_LOW:  phase_next = half_end ? PH_HIGH : PH_LOW;
            PH_HIGH: phase_next = half_end ? (last_bit ? PH_IDLE : PH_LOW) : PH_HIGH;
            default: phase_next = PH_IDLE;
        endcase
    end

    // pins, shifters and completion
    always_comb
    begin
        logic [31:0] tx_e;
        op_t         held_e;
        logic [7:0]  exp_e;
        logic        rl_e;
        tx_e   = start ? build_frame(op_t'(item.opcode), item.address & ADDR_MASK,
                                     item.wr_data) : tx_reg;
        held_e = start ? op_t'(item.opcode) : held_reg;
        exp_e  = start ? item.wr_data : exp_reg;
        rl_e   = (start && (item.opcode == 3'(OP_BEGIN))) ? 1'b1 :
                 (stop_cmd ? 1'b0 : rl_reg);

        rx_next   = sample ? {rx_reg[6:0], item.miso} : rx_reg;
        tx_next   = tx_e;
        div_next  = div_e;
        bit_next  = bit_e;
        held_next = held_e;
        exp_next  = exp_e;
        rl_next   = rl_e;

        result.busy   = (ph_e != PH_IDLE);
        result.done   = stop_cmd;
        result.status = ST_OK;

        if (ph_e != PH_IDLE)
        begin
            result.sck  = (ph_e == PH_HIGH);
            result.mosi = tx_e[31];
            div_next    = half_end ? 8'd0 : div_inc[7:0];
            if (sample)
            begin
                tx_next = {tx_e[30:0], 1'b0};
                if (last_bit)
                begin
                    bit_next    = 5'd0;
                    result.done = 1'b1;
                    if (held_e == OP_BEGIN && rx_next != ENABLE_ECHO)
                    begin
                        result.status = ST_ENABLE_FAIL;
                        rl_next       = 1'b0;
                    end
                    else if (held_e == OP_READ && rx_next != exp_e)
                    begin
                        result.status = ST_VERIFY_FAIL;
                        rl_next       = 1'b0;
                    end
                end
                else
                begin
                    bit_next = bit_e + 5'd1;
                end
            end
        end
        else
        begin
            result.sck  = ~rl_e;
            result.mosi = ~rl_e;
        end

        result.target_reset = rl_next;
        result.read_byte    = rx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            bit_reg   <= 5'd0;
            tx_reg    <= 32'd0;
            rx_reg    <= 8'd0;
            div_reg   <= 8'd0;
            held_reg  <= OP_BEGIN;
            exp_reg   <= 8'd0;
            rl_reg    <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            bit_reg   <= bit_next;
            tx_reg    <= tx_next;
            rx_reg    <= rx_next;
            div_reg   <= div_next;
            held_reg  <= held_next;
            exp_reg   <= exp_next;
            rl_reg    <= rl_next;
        end
    end

endmodule

/* design/isp_flash_programmer_sequencer_unit.sv */
// top level of the serial in-system flash programmer sequencer
//
// each input word is one tick of the pin sequencer: an optional command
// (begin, chip erase, write byte, read verify, end) and the sampled miso
// level. every input word yields exactly one result word with the sck,
// mosi and target reset pin levels, busy, done, status and the receive byte
// input channel: in_valid / in_stall, word taken when valid and not stall
// result channel: out_valid / out_stall, word taken likewise
// config channel: cfg_valid / cfg_ready carrying half_period_ticks; ready is
// always high, write only while no words are in flight
// the path is an input register, then the tick logic feeding the result
// register. one word per cycle is sustained while the result channel does
// not stall; the only loop is the sequencer state fed back through the tick logic
// a stalled result holds in the result register while one more input word
// waits in the input register; in_stall rises only when both are full
// reset clears the valid flags of both registers, releases the target (reset
// pin low, idle pins high) and sets the half period to one tick
module isp_flash_programmer_sequencer_unit #(
    parameter int unsigned ADDR_BITS = ispfp_pkg::ADDR_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // tick input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd_valid,
    input  logic [2:0]  opcode,
    input  logic [15:0] address,
    input  logic [7:0]  wr_data,
    input  logic        miso,
    // result output
    output logic        out_valid,
    input  logic        out_stall,
    output logic        sck,
    output logic        mosi,
    output logic        target_reset,
    output logic        busy_res,
    output logic        done_res,
    output logic [1:0]  status,
    output logic [7:0]  read_byte,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);
    import ispfp_pkg::*;

    logic    in_vld_reg, in_vld_next;
    item_t   in_item_reg;
    logic    out_vld_reg, out_vld_next;
    result_t out_res_reg, step_res;
    logic [7:0] half_reg;
    logic    advance, accept, step_en;

    // result register free or draining this cycle
    assign advance  = ~out_vld_reg | ~out_stall;
    assign in_stall = in_vld_reg & ~advance;
    assign accept   = in_valid & ~in_stall;
    assign step_en  = in_vld_reg & advance;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        in_vld_next  = accept ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
        out_vld_next = advance ? in_vld_reg : out_vld_reg;
    end

    ispfp_seq_core #(
        .ADDR_BITS (ADDR_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (step_en),
        .item        (in_item_reg),
        .half_period (half_reg),
        .result      (step_res)
    );

    // handshake and configuration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            half_reg    <= 8'd1;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (cfg_valid && cfg_ready)
            begin
                half_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= '{cmd_valid: cmd_valid, opcode: opcode, address: address,
                             wr_data: wr_data, miso: miso};
        end
        if (step_en)
        begin
            out_res_reg <= step_res;
        end
    end

    assign out_valid    = out_vld_reg;
    assign sck          = out_res_reg.sck;
    assign mosi         = out_res_reg.mosi;
    assign target_reset = out_res_reg.target_reset;
    assign busy_res     = out_res_reg.busy;
    assign done_res     = out_res_reg.done;
    assign status       = out_res_reg.status;
    assign read_byte    = out_res_reg.read_byte;

endmodule

/* design/ispfp_checker.sv */
// port-level checks on the programmer sequencer, bound to the top level
`include "isp_flash_programmer_sequencer_unit_macros.svh"

module ispfp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       sck,
    input logic       mosi,
    input logic       target_reset,
    input logic       busy_res,
    input logic       done_res,
    input logic [1:0] status,
    input logic [7:0] read_byte
);
    import ispfp_pkg::*;

    // a failure code only comes with completion and always drops reset
    `ISPFP_CHECK(a_fail_done, (out_valid && status != ST_OK) |-> (done_res && !target_reset), "failure status without done or with reset held")

    // an end command completes outside a frame with the target released
    `ISPFP_CHECK(a_end_release, (out_valid && done_res && !busy_res) |-> (status == ST_OK && !target_reset), "end command left reset held")

    // idle pins follow the inverse of the reset level
    `ISPFP_CHECK(a_idle_pins, (out_valid && !busy_res) |-> (sck == !target_reset && mosi == !target_reset), "idle pin levels wrong")

    // a stalled result word holds
    `ISPFP_HOLD(a_out_hold, out_valid, out_stall, {sck, mosi, target_reset, busy_res, done_res, status, read_byte}, "result word changed under stall")

endmodule

bind isp_flash_programmer_sequencer_unit ispfp_checker u_ispfp_checker (.*);

/* sim/ispfp_tick_monitor.sv */
// tick predictor and result comparison for the serial programmer sequencer
module ispfp_tick_monitor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        cmd_valid,
    input  logic [2:0]  opcode,
    input  logic [15:0] address,
    input  logic [7:0]  wr_data,
    input  logic        miso,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        sck,
    input  logic        mosi,
    input  logic        target_reset,
    input  logic        busy_res,
    input  logic        done_res,
    input  logic [1:0]  status,
    input  logic [7:0]  read_byte,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    output int unsigned fail_count,
    output int unsigned pending
);
    import ispfp_pkg::*;

    // sequencer copy
    logic [7:0]  half_ticks;
    phase_t      seq_state;
    logic [4:0]  bit_cnt;
    logic [31:0] frame_sr;
    logic [7:0]  rx_sr;
    logic [7:0]  div_cnt;
    op_t         cur_op;
    logic [7:0]  verify_byte;
    logic        tgt_hold;

    result_t     pin_queue[$];

    function automatic result_t tick_predict(logic cv, logic [2:0] op, logic [15:0] ad,
                                             logic [7:0] wd, logic mi);
        int      hp;
        result_t r;
        begin
            hp = (half_ticks == 8'd0) ? 1 : int'(half_ticks);
            r = '0;
            r.status = ST_OK;
            if (seq_state == PH_IDLE && cv) begin
                if (op <= OP_READ) begin
                    if (op == OP_BEGIN)
                        tgt_hold = 1'b1;
                    case (op_t'(op))
                        OP_BEGIN: frame_sr = {PROG_ENABLE, ENABLE_B1, 8'h00, ENABLE_B3};
                        OP_ERASE: frame_sr = {PROG_ENABLE, ERASE_B1, ERASE_B2, ERASE_B3};
                        OP_WRITE: frame_sr = {WRITE_INSTR, ad, wd};
                        default:  frame_sr = {READ_INSTR, ad, 8'h00};
                    endcase
                    cur_op = op_t'(op);
                    verify_byte = wd;
                    bit_cnt = '0;
                    div_cnt = '0;
                    seq_state = PH_LOW;
                end else if (op == OP_END) begin
                    tgt_hold = 1'b0;
                    r.done = 1'b1;
                end
            end
            if (seq_state != PH_IDLE) begin
                r.busy = 1'b1;
                r.sck = (seq_state == PH_HIGH);
                r.mosi = frame_sr[31];
                if (int'(div_cnt) + 1 < hp) begin
                    div_cnt = div_cnt + 8'd1;
                end else begin
                    div_cnt = '0;
                    if (seq_state == PH_LOW) begin
                        seq_state = PH_HIGH;
                    end else begin
                        rx_sr = {rx_sr[6:0], mi};
                        frame_sr = frame_sr << 1;
                        if (bit_cnt == 5'd31) begin
                            seq_state = PH_IDLE;
                            bit_cnt = '0;
                            r.done = 1'b1;
                            if (cur_op == OP_BEGIN && rx_sr != ENABLE_ECHO) begin
                                r.status = ST_ENABLE_FAIL;
                                tgt_hold = 1'b0;
                            end else if (cur_op == OP_READ && rx_sr != verify_byte) begin
                                r.status = ST_VERIFY_FAIL;
                                tgt_hold = 1'b0;
                            end
                        end else begin
                            bit_cnt = bit_cnt + 5'd1;
                            seq_state = PH_LOW;
                        end
                    end
                end
            end else begin
                // idle pins follow the inverse of the target reset level
                r.sck = !tgt_hold;
                r.mosi = !tgt_hold;
            end
            r.target_reset = tgt_hold;
            r.read_byte = rx_sr;
            return r;
        end
    endfunction

    task automatic compare_field(string fname, int want, int got);
        begin
            if (want != got) begin
                fail_count++;
                $display("%0t: %s mismatch, expected %0h actual %0h",
                         $time, fname, want, got);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            half_ticks = 8'd1;
            seq_state = PH_IDLE;
            bit_cnt = '0;
            frame_sr = '0;
            rx_sr = '0;
            div_cnt = '0;
            cur_op = OP_BEGIN;
            verify_byte = '0;
            tgt_hold = 1'b0;
            pin_queue.delete();
            fail_count = 0;
            pending <= 0;
        end else begin
            if (cfg_valid && cfg_ready)
                half_ticks = cfg_data;
            if (out_valid && !out_stall) begin
                if (pin_queue.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result word, expected none actual %0h",
                             $time, {sck, mosi, target_reset, busy_res, done_res,
                                     status, read_byte});
                end else begin
                    want = pin_queue.pop_front();
                    compare_field("sck", int'(want.sck), int'(sck));
                    compare_field("mosi", int'(want.mosi), int'(mosi));
                    compare_field("target_reset", int'(want.target_reset),
                                  int'(target_reset));
                    compare_field("busy_res", int'(want.busy), int'(busy_res));
                    compare_field("done_res", int'(want.done), int'(done_res));
                    compare_field("status", int'(want.status), int'(status));
                    compare_field("read_byte", int'(want.read_byte), int'(read_byte));
                end
            end
            if (in_valid && !in_stall)
                pin_queue.push_back(tick_predict(cmd_valid, opcode, address, wr_data, miso));
            pending <= pin_queue.size();
        end
    end

endmodule

/* sim/testbench.sv */
// stimulus and verdict for the serial programmer sequencer
module testbench;
    import ispfp_pkg::*;

    // run limit in time units, far beyond the slowest legal run
    localparam int RUN_LIMIT    = 1000000;
    localparam int RANDOM_TICKS = 120;
    localparam int HOLD_CYCLES  = 80;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        cmd_valid;
    logic [2:0]  opcode;
    logic [15:0] address;
    logic [7:0]  wr_data;
    logic        miso;
    logic        out_valid;
    logic        out_stall;
    logic        sck;
    logic        mosi;
    logic        target_reset;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  status;
    logic [7:0]  read_byte;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;

    int unsigned fail_count;
    int unsigned pending;

    // stimulus bookkeeping
    int          burst_left = 0;
    int          ticks_sent = 0;
    int          cur_hp = 1;
    bit          hold_req = 1'b0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    isp_flash_programmer_sequencer_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd_valid    (cmd_valid),
        .opcode       (opcode),
        .address      (address),
        .wr_data      (wr_data),
        .miso         (miso),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sck          (sck),
        .mosi         (mosi),
        .target_reset (target_reset),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .status       (status),
        .read_byte    (read_byte),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    // watches all three channels, predicts every tick and compares
    ispfp_tick_monitor u_monitor (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd_valid    (cmd_valid),
        .opcode       (opcode),
        .address      (address),
        .wr_data      (wr_data),
        .miso         (miso),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sck          (sck),
        .mosi         (mosi),
        .target_reset (target_reset),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .status       (status),
        .read_byte    (read_byte),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // offer one tick word; the sender runs in bursts with random gaps, and a
    // gap of zero keeps valid high straight into the next burst
    task automatic offer_tick(logic cv, logic [2:0] op, logic [15:0] ad,
                              logic [7:0] wd, logic mi);
        int gap;
        begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 40);
            end
            in_valid  <= 1'b1;
            cmd_valid <= cv;
            opcode    <= op;
            address   <= ad;
            wr_data   <= wd;
            miso      <= mi;
            do @(posedge clk); while (in_stall);
            burst_left--;
            ticks_sent++;
        end
    endtask

    // ticks with random content; commands only when asked for
    task automatic noise_ticks(int count, bit with_cmd);
        begin
            repeat (count)
                offer_tick(with_cmd ? 1'($urandom_range(0, 1)) : 1'b0,
                           3'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
        end
    endtask

    // stop sending and let every expected word come back
    task automatic drain_results;
        begin
            in_valid <= 1'b0;
            burst_left = 0;
            do @(posedge clk); while (pending != 0);
        end
    endtask

    // register write, only with nothing in flight
    task automatic write_half_period(logic [7:0] value);
        begin
            drain_results();
            cfg_data  <= value;
            cfg_valid <= 1'b1;
            do @(posedge clk); while (!cfg_ready);
            cfg_valid <= 1'b0;
            cur_hp = int'(value);
        end
    endtask

    // one command and the ticks of its frame; miso carries the planned reply
    // bit on every sampling tick and random levels elsewhere, while random
    // commands during the frame must be ignored as busy. a tick cap below
    // the frame length leaves the frame unfinished
    task automatic play_frame(op_t op, logic [15:0] ad, logic [7:0] wd,
                              logic [7:0] echo, int tick_cap);
        logic [31:0] reply;
        int          eff;
        int          total;
        int          bitpos;
        logic        planned;
        logic        mi;
        begin
            reply = {24'($urandom), echo};
            eff = (cur_hp == 0) ? 1 : cur_hp;
            total = 64 * eff;
            if (tick_cap > 0 && tick_cap < total)
                total = tick_cap;
            for (int t = 0; t < total; t++) begin
                bitpos = t / (2 * eff);
                planned = reply[31 - bitpos];
                if ((t % (2 * eff)) == 2 * eff - 1 || $urandom_range(0, 1))
                    mi = planned;
                else
                    mi = 1'($urandom);
                if (t == 0)
                    offer_tick(1'b1, op, ad, wd, mi);
                else
                    offer_tick($urandom_range(0, 2) == 0, 3'($urandom), 16'($urandom),
                               8'($urandom), mi);
            end
        end
    endtask

    // a well-formed frame with random content, mostly with the good reply
    task automatic random_frame(int tick_cap);
        op_t        op;
        logic [7:0] wd;
        logic [7:0] echo;
        bit         good;
        begin
            op = op_t'($urandom_range(int'(OP_BEGIN), int'(OP_READ)));
            wd = 8'($urandom);
            good = ($urandom_range(0, 99) < 85);
            echo = 8'($urandom);
            if (good && op == OP_BEGIN)
                echo = ENABLE_ECHO;
            else if (good && op == OP_READ)
                echo = wd;
            play_frame(op, 16'($urandom), wd, echo, tick_cap);
        end
    endtask

    // receiver: stretches of its own stall pattern, plus one long hold-off
    // once the random part asks for it, with the sender still pushing
    initial begin
        bit hold_done;
        int mode;
        int seg;
        hold_done = 1'b0;
        out_stall <= 1'b0;
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                @(posedge clk);
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end else begin
                mode = $urandom_range(0, 3);
                seg = $urandom_range(4, 50);
                repeat (seg) begin
                    @(posedge clk);
                    case (mode)
                        0:       out_stall <= 1'b0;
                        1:       out_stall <= ($urandom_range(0, 3) == 0);
                        2:       out_stall <= 1'($urandom_range(0, 1));
                        default: out_stall <= ($urandom_range(0, 3) != 0);
                    endcase
                end
            end
        end
    end

    initial begin
        int pick;
        int random_start;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        cmd_valid <= 1'b0;
        opcode    <= OP_BEGIN;
        address   <= '0;
        wr_data   <= '0;
        miso      <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: idle pins after reset, end while released, unknown opcodes
        noise_ticks(3, 1'b0);
        offer_tick(1'b1, OP_END, 16'($urandom), 8'($urandom), 1'($urandom));
        for (int u = int'(OP_END) + 1; u < 8; u++)
            offer_tick(1'b1, 3'(u), 16'($urandom), 8'($urandom), 1'($urandom));

        // erase with the target never put into programming mode
        write_half_period(8'd1);
        play_frame(OP_ERASE, 16'($urandom), 8'($urandom), 8'($urandom), 0);

        // good enable, then enable again while held with a bad echo
        play_frame(OP_BEGIN, 16'($urandom), 8'($urandom), ENABLE_ECHO, 0);
        noise_ticks(2, 1'b0);
        play_frame(OP_BEGIN, 16'($urandom), 8'($urandom), ~ENABLE_ECHO, 0);

        // address and data extremes, verify pass and verify miss
        play_frame(OP_BEGIN, 16'h0000, 8'h00, ENABLE_ECHO, 0);
        play_frame(OP_WRITE, 16'hffff, 8'hff, 8'($urandom), 0);
        play_frame(OP_WRITE, 16'h0000, 8'h00, 8'($urandom), 0);
        play_frame(OP_READ, 16'hffff, 8'ha5, 8'ha5, 0);
        play_frame(OP_READ, 16'h0000, 8'h00, 8'hff, 0);
        offer_tick(1'b1, OP_END, 16'($urandom), 8'($urandom), 1'($urandom));

        // zero half period behaves as one tick, then a slower clock
        write_half_period(8'd0);
        play_frame(OP_BEGIN, 16'($urandom), 8'($urandom), ENABLE_ECHO, 0);
        write_half_period(8'd2);
        play_frame(OP_READ, 16'h1234, 8'h5a, 8'h5a, 0);

        // longest half period, cut short to one tick mid-frame; the half
        // period in progress has outrun the new length and ends at once
        write_half_period(8'd255);
        play_frame(OP_ERASE, 16'($urandom), 8'($urandom), 8'($urandom), 280);
        write_half_period(8'd1);
        noise_ticks(80, 1'b0);
        offer_tick(1'b1, OP_END, 16'($urandom), 8'($urandom), 1'($urandom));

        // random part: mostly whole frames, some register changes, end
        // commands, unknown opcodes, cut frames and raw noise
        random_start = ticks_sent;
        hold_req = 1'b1;
        while (ticks_sent - random_start < RANDOM_TICKS) begin
            pick = $urandom_range(0, 19);
            if (pick < 2) begin
                case ($urandom_range(0, 4))
                    0:       write_half_period(8'd0);
                    1:       write_half_period(8'd2);
                    2:       write_half_period(8'd3);
                    default: write_half_period(8'd1);
                endcase
            end else if (pick < 14) begin
                random_frame(0);
            end else if (pick < 17) begin
                offer_tick(1'b1, OP_END, 16'($urandom), 8'($urandom), 1'($urandom));
            end else if (pick == 17) begin
                offer_tick(1'b1, 3'($urandom_range(int'(OP_END) + 1, 7)),
                           16'($urandom), 8'($urandom), 1'($urandom));
            end else if (pick == 18) begin
                random_frame($urandom_range(1, 63));
            end else begin
                noise_ticks($urandom_range(1, 20), 1'b1);
            end
            noise_ticks($urandom_range(0, 3), 1'b0);
        end

        // let the pipe empty before the verdict
        drain_results();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // hard stop should anything hang
    initial begin
        #RUN_LIMIT;
        $display("testbench: errors");
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/ispfp_pkg.sv
design/ispfp_seq_core.sv
design/isp_flash_programmer_sequencer_unit.sv
design/ispfp_checker.sv
sim/ispfp_tick_monitor.sv
sim/testbench.sv
